### rtl/esc_pkg.sv
// Package with the word types, codes and constants of the ELF segment security checker.
package esc_pkg;

  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] ELF_MAGIC_WORD = 32'h464C457F;
  localparam logic [7:0]  CLASS_64       = 8'd2;
  localparam logic [15:0] TYPE_EXEC      = 16'd2;
  localparam logic [15:0] TYPE_DYN       = 16'd3;
  localparam logic [31:0] SEG_LOAD       = 32'd1;
  localparam logic [31:0] SEG_STACK      = 32'h6474E551;
  localparam int unsigned FLAG_X_BIT     = 0;
  localparam int unsigned FLAG_W_BIT     = 1;

  localparam logic [31:0] PAD_LIMIT_RESET = 32'd102400;
  localparam logic [15:0] MACHINE_RESET   = 16'd62;

  typedef enum logic [0:0] {
    REG_PAD_LIMIT = 1'b0,
    REG_MACHINE   = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_HEADER  = 2'd0,
    OP_SEGMENT = 2'd1,
    OP_END     = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_SEGMENT = 2'd1,
    KIND_FINAL   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REJ_OK        = 3'd0,
    REJ_MAGIC     = 3'd1,
    REJ_CLASS     = 3'd2,
    REJ_TYPE      = 3'd3,
    REJ_MACHINE   = 3'd4,
    REJ_NO_LOAD   = 3'd5
  } reject_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] ident_magic;
    logic [7:0]  ident_class;
    logic [15:0] file_type;
    logic [15:0] machine;
    logic [63:0] entry_addr;
    logic [31:0] seg_type;
    logic [2:0]  seg_flags;
    logic [63:0] seg_file_size;
    logic [63:0] seg_mem_size;
    logic [63:0] seg_vaddr;
  } esc_in_t;

  typedef struct packed {
    logic [1:0]  report_kind;
    logic [2:0]  reject_code;
    logic        wx_violation;
    logic        size_gap_alert;
    logic [63:0] size_gap;
    logic        stack_exec_alert;
    logic        stack_missing;
    logic        stack_repeated;
    logic        entry_writable;
    logic        entry_unmapped;
  } esc_out_t;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    reject_t     verdict;
    logic        is_load;
    logic        is_stack;
    logic        writable;
    logic        wx;
    logic        gap_alert;
    logic [63:0] gap;
    logic        stack_exec;
    logic        holds_entry;
  } esc_cls_t;

endpackage

### rtl/esc_front.sv
// Front end: configuration registers, input word intake and classification.
module esc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [0:0]                      wr_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]  wr_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  esc_pkg::esc_in_t                item,
  output logic                            cls_valid,
  input  logic                            cls_ready,
  output esc_pkg::esc_cls_t               cls
);

  logic [31:0]       pad_limit;
  logic [15:0]       exp_machine;
  logic [63:0]       entry_point;
  esc_pkg::esc_cls_t cls_next;
  esc_pkg::reject_t  verdict;
  logic [64:0]       seg_end;
  logic [63:0]       gap_raw;
  logic              mem_larger;
  logic              doubles;
  logic              over_pad;
  logic              is_load;
  logic              is_stack;
  logic              wr_flag;
  logic              ex_flag;
  logic              take;

  assign item_ready = !cls_valid || cls_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    if (item.ident_magic != esc_pkg::ELF_MAGIC_WORD) begin
      verdict = esc_pkg::REJ_MAGIC;
    end else if (item.ident_class != esc_pkg::CLASS_64) begin
      verdict = esc_pkg::REJ_CLASS;
    end else if (item.file_type != esc_pkg::TYPE_EXEC && item.file_type != esc_pkg::TYPE_DYN) begin
      verdict = esc_pkg::REJ_TYPE;
    end else if (item.machine != exp_machine) begin
      verdict = esc_pkg::REJ_MACHINE;
    end else begin
      verdict = esc_pkg::REJ_OK;
    end
  end

  assign is_load    = item.seg_type == esc_pkg::SEG_LOAD;
  assign is_stack   = item.seg_type == esc_pkg::SEG_STACK;
  assign wr_flag    = item.seg_flags[esc_pkg::FLAG_W_BIT];
  assign ex_flag    = item.seg_flags[esc_pkg::FLAG_X_BIT];
  assign mem_larger = item.seg_mem_size > item.seg_file_size;
  assign gap_raw    = item.seg_mem_size - item.seg_file_size;
  assign doubles    = {1'b0, item.seg_mem_size} >= {item.seg_file_size, 1'b0};
  assign over_pad   = gap_raw > {32'd0, pad_limit};
  assign seg_end    = {1'b0, item.seg_vaddr} + {1'b0, item.seg_mem_size};

  always_comb begin
    cls_next = '0;
    case (item.op)
      esc_pkg::OP_HEADER: begin
        cls_next.kind    = esc_pkg::KIND_HEADER;
        cls_next.verdict = verdict;
      end
      esc_pkg::OP_SEGMENT: begin
        cls_next.kind        = esc_pkg::KIND_SEGMENT;
        cls_next.is_load     = is_load;
        cls_next.is_stack    = is_stack && !is_load;
        cls_next.writable    = wr_flag;
        cls_next.wx          = is_load && wr_flag && ex_flag;
        cls_next.gap_alert   = is_load && mem_larger && (doubles || over_pad);
        cls_next.gap         = (is_load && mem_larger) ? gap_raw : 64'd0;
        cls_next.stack_exec  = is_stack && ex_flag;
        cls_next.holds_entry = is_load && (entry_point >= item.seg_vaddr) &&
                               ({1'b0, entry_point} < seg_end);
      end
      esc_pkg::OP_END: begin
        cls_next.kind = esc_pkg::KIND_FINAL;
      end
      default: begin
        cls_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_limit   <= esc_pkg::PAD_LIMIT_RESET;
      exp_machine <= esc_pkg::MACHINE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        esc_pkg::REG_PAD_LIMIT: pad_limit   <= wr_data;
        esc_pkg::REG_MACHINE:   exp_machine <= wr_data[15:0];
        default:                pad_limit   <= pad_limit;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid   <= 1'b0;
      entry_point <= 64'd0;
    end else begin
      if (item_ready) begin
        cls_valid <= item_valid && (item.op != esc_pkg::OP_NONE);
      end
      if (take && item.op == esc_pkg::OP_HEADER) begin
        entry_point <= item.entry_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      cls <= cls_next;
    end
  end

endmodule

### rtl/esc_queue.sv
// Two-entry queue of classified words between the front end and the back end.
module esc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  esc_pkg::esc_cls_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output esc_pkg::esc_cls_t pop_data
);

  esc_pkg::esc_cls_t slots [2];
  logic              wptr;
  logic              rptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

### rtl/esc_back.sv
// Back end: per-table state, verdict tracking and the registered report output.
module esc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cls_valid,
  output logic              cls_ready,
  input  esc_pkg::esc_cls_t cls,
  output logic              report_valid,
  input  logic              report_ready,
  output esc_pkg::esc_out_t report
);

  esc_pkg::reject_t  header_verdict;
  logic              load_seen;
  logic [1:0]        stack_count;
  logic              entry_located;
  logic              entry_seg_writable;
  esc_pkg::esc_out_t report_next;
  esc_pkg::reject_t  final_code;
  logic              take;

  assign cls_ready = !report_valid || report_ready;
  assign take      = cls_valid && cls_ready;

  assign final_code = (header_verdict == esc_pkg::REJ_OK && !load_seen) ?
                      esc_pkg::REJ_NO_LOAD : header_verdict;

  always_comb begin
    report_next             = '0;
    report_next.report_kind = cls.kind;
    case (cls.kind)
      esc_pkg::KIND_HEADER: begin
        report_next.reject_code = cls.verdict;
      end
      esc_pkg::KIND_SEGMENT: begin
        report_next.wx_violation     = cls.wx;
        report_next.size_gap_alert   = cls.gap_alert;
        report_next.size_gap         = cls.gap;
        report_next.stack_exec_alert = cls.stack_exec;
      end
      esc_pkg::KIND_FINAL: begin
        report_next.reject_code = final_code;
        if (final_code == esc_pkg::REJ_OK) begin
          report_next.stack_missing  = stack_count == 2'd0;
          report_next.stack_repeated = stack_count == 2'd2;
          report_next.entry_writable = entry_located && entry_seg_writable;
          report_next.entry_unmapped = !entry_located;
        end
      end
      default: begin
        report_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid       <= 1'b0;
      header_verdict     <= esc_pkg::REJ_OK;
      load_seen          <= 1'b0;
      stack_count        <= 2'd0;
      entry_located      <= 1'b0;
      entry_seg_writable <= 1'b0;
    end else begin
      if (cls_ready) begin
        report_valid <= cls_valid;
      end
      if (take) begin
        case (cls.kind)
          esc_pkg::KIND_HEADER: begin
            header_verdict     <= cls.verdict;
            load_seen          <= 1'b0;
            stack_count        <= 2'd0;
            entry_located      <= 1'b0;
            entry_seg_writable <= 1'b0;
          end
          esc_pkg::KIND_SEGMENT: begin
            if (cls.is_load) begin
              load_seen <= 1'b1;
              if (!entry_located && cls.holds_entry) begin
                entry_located      <= 1'b1;
                entry_seg_writable <= cls.writable;
              end
            end
            if (cls.is_stack && stack_count != 2'd2) begin
              stack_count <= stack_count + 2'd1;
            end
          end
          esc_pkg::KIND_FINAL: begin
            load_seen          <= 1'b0;
            stack_count        <= 2'd0;
            entry_located      <= 1'b0;
            entry_seg_writable <= 1'b0;
          end
          default: begin
            load_seen <= load_seen;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cls_ready) begin
      report <= report_next;
    end
  end

endmodule

### rtl/elf_segment_security_checker.sv
// Top level of the ELF segment security checker.
// The block accepts one word per clock while the report side is ready and
// returns one report word for every file header, program header and
// end-of-table word (op 3 words are dropped with no report). An accepted word
// is registered in the classify register, then held in the two-entry queue
// and then loaded into the output register. The front end holds the
// configuration registers and the entry point and does the wide compares; the
// back end keeps the per-table state and builds the reports. Configuration
// writes take effect at the next edge and are meant to be made while no word
// is in flight.
module elf_segment_security_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [0:0]                      wr_index,
  input  logic [esc_pkg::CFG_DATA_W-1:0]  wr_data,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  esc_pkg::esc_in_t                item,
  output logic                            report_valid,
  input  logic                            report_ready,
  output esc_pkg::esc_out_t               report
);

  logic              front_valid;
  logic              front_ready;
  esc_pkg::esc_cls_t front_cls;
  logic              back_valid;
  logic              back_ready;
  esc_pkg::esc_cls_t back_cls;

  esc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cls_valid  (front_valid),
    .cls_ready  (front_ready),
    .cls        (front_cls)
  );

  esc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cls),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cls)
  );

  esc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cls_valid    (back_valid),
    .cls_ready    (back_ready),
    .cls          (back_cls),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

endmodule

### rtl/esc_checker.sv
// Port-level checker for the ELF segment security checker and its bind.
module esc_checker (
  input logic              clk,
  input logic              rst,
  input logic              report_valid,
  input logic              report_ready,
  input esc_pkg::esc_out_t report
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !report_valid)
    else $error("Report word shown right after reset.");

  a_report_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(report))
    else $error("Stalled report word changed or dropped.");

  a_final_reject_clean: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.report_kind == esc_pkg::KIND_FINAL &&
    report.reject_code != esc_pkg::REJ_OK
    |-> !report.stack_missing && !report.stack_repeated &&
        !report.entry_writable && !report.entry_unmapped)
    else $error("Rejected final report carries flags.");

  a_segment_clean: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.report_kind == esc_pkg::KIND_SEGMENT
    |-> report.reject_code == esc_pkg::REJ_OK &&
        !report.stack_missing && !report.stack_repeated &&
        !report.entry_writable && !report.entry_unmapped &&
        !(report.stack_exec_alert && (report.wx_violation || report.size_gap_alert)))
    else $error("Segment report carries fields of another kind.");

  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.report_kind == esc_pkg::KIND_HEADER
    |-> report.reject_code != esc_pkg::REJ_NO_LOAD && report.size_gap == 64'd0 &&
        !report.wx_violation && !report.stack_exec_alert && !report.entry_unmapped)
    else $error("Header report carries segment or final fields.");

endmodule

bind elf_segment_security_checker esc_checker u_esc_checker (
  .clk          (clk),
  .rst          (rst),
  .report_valid (report_valid),
  .report_ready (report_ready),
  .report       (report)
);

### tb/esc_report_checker.sv
// Report checker for the ELF segment security checker: predicts every report word and compares.
`timescale 1ns / 100ps
module esc_report_checker
  import esc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [0:0]             wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  esc_in_t                item,
  input  logic                   report_valid,
  input  logic                   report_ready,
  input  esc_out_t               report,
  output int                     fail_count,
  output int                     pending,
  output int                     reports_seen
);

  logic [31:0] pad_limit;
  logic [15:0] machine_code;
  logic [63:0] entry_point;
  reject_t     header_code;
  logic        load_seen;
  logic [1:0]  stack_count;
  logic        entry_found;
  logic        entry_seg_wr;
  esc_out_t    expected_reports[$];

  function automatic void clear_table();
    load_seen    = 1'b0;
    stack_count  = 2'd0;
    entry_found  = 1'b0;
    entry_seg_wr = 1'b0;
  endfunction

  task automatic predict_report(input esc_in_t w, output esc_out_t r);
    logic [64:0] seg_end;
    logic [63:0] gap;
    reject_t     code;
    logic        wr;
    r = '0;
    case (op_t'(w.op))
      OP_HEADER: begin
        code = REJ_OK;
        if (w.ident_magic != ELF_MAGIC_WORD) begin
          code = REJ_MAGIC;
        end else if (w.ident_class != CLASS_64) begin
          code = REJ_CLASS;
        end else if (w.file_type != TYPE_EXEC && w.file_type != TYPE_DYN) begin
          code = REJ_TYPE;
        end else if (w.machine != machine_code) begin
          code = REJ_MACHINE;
        end
        header_code = code;
        entry_point = w.entry_addr;
        clear_table();
        r.report_kind = KIND_HEADER;
        r.reject_code = code;
      end
      OP_SEGMENT: begin
        r.report_kind = KIND_SEGMENT;
        if (w.seg_type == SEG_LOAD) begin
          wr = w.seg_flags[FLAG_W_BIT];
          load_seen = 1'b1;
          r.wx_violation = wr && w.seg_flags[FLAG_X_BIT];
          if (w.seg_mem_size > w.seg_file_size) begin
            gap = w.seg_mem_size - w.seg_file_size;
            r.size_gap = gap;
            r.size_gap_alert = ({1'b0, w.seg_mem_size} >= {w.seg_file_size, 1'b0}) ||
                               (gap > {32'd0, pad_limit});
          end
          if (!entry_found) begin
            seg_end = {1'b0, w.seg_vaddr} + {1'b0, w.seg_mem_size};
            if (entry_point >= w.seg_vaddr && {1'b0, entry_point} < seg_end) begin
              entry_found  = 1'b1;
              entry_seg_wr = wr;
            end
          end
        end else if (w.seg_type == SEG_STACK) begin
          if (stack_count != 2'd2) begin
            stack_count = stack_count + 2'd1;
          end
          r.stack_exec_alert = w.seg_flags[FLAG_X_BIT];
        end
      end
      OP_END: begin
        code = header_code;
        if (code == REJ_OK && !load_seen) begin
          code = REJ_NO_LOAD;
        end
        r.report_kind = KIND_FINAL;
        r.reject_code = code;
        if (code == REJ_OK) begin
          r.stack_missing  = (stack_count == 2'd0);
          r.stack_repeated = (stack_count == 2'd2);
          r.entry_writable = entry_found && entry_seg_wr;
          r.entry_unmapped = !entry_found;
        end
        clear_table();
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    esc_out_t want;
    if (rst) begin
      pad_limit    = PAD_LIMIT_RESET;
      machine_code = MACHINE_RESET;
      entry_point  = '0;
      header_code  = REJ_OK;
      clear_table();
      expected_reports.delete();
      fail_count   = 0;
      reports_seen = 0;
    end else begin
      if (report_valid && report_ready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          $error("report word with no word waiting for it: %p", report);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_kind", 64'(want.report_kind), 64'(report.report_kind));
          check_field("reject_code", 64'(want.reject_code), 64'(report.reject_code));
          check_field("wx_violation", 64'(want.wx_violation), 64'(report.wx_violation));
          check_field("size_gap_alert", 64'(want.size_gap_alert),
                      64'(report.size_gap_alert));
          check_field("size_gap", want.size_gap, report.size_gap);
          check_field("stack_exec_alert", 64'(want.stack_exec_alert),
                      64'(report.stack_exec_alert));
          check_field("stack_missing", 64'(want.stack_missing), 64'(report.stack_missing));
          check_field("stack_repeated", 64'(want.stack_repeated),
                      64'(report.stack_repeated));
          check_field("entry_writable", 64'(want.entry_writable),
                      64'(report.entry_writable));
          check_field("entry_unmapped", 64'(want.entry_unmapped),
                      64'(report.entry_unmapped));
        end
      end
      if (item_valid && item_ready && op_t'(item.op) != OP_NONE) begin
        predict_report(item, want);
        expected_reports.insert(expected_reports.size(), want);
      end
      if (wr_en) begin
        case (reg_index_t'(wr_index))
          REG_PAD_LIMIT: pad_limit = wr_data;
          REG_MACHINE:   machine_code = wr_data[15:0];
          default: ;
        endcase
      end
    end
    pending = expected_reports.size();
  end

endmodule

### tb/tb_elf_segment_security_checker.sv
// Testbench top for the ELF segment security checker: stimulus, report stalls and verdict.
`timescale 1ns / 100ps
module tb_elf_segment_security_checker;
  import esc_pkg::*;

  localparam int IN_W          = $bits(esc_in_t);
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_WORDS   = 120;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  wr_en = 1'b0;
  logic [0:0]            wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  esc_in_t               item = '0;
  logic                  report_valid;
  logic                  report_ready = 1'b0;
  esc_out_t              report;

  int fail_count;
  int pending;
  int reports_seen;

  bit          idle_enable = 1'b1;
  logic [31:0] pad_cfg = PAD_LIMIT_RESET;
  logic [15:0] mach_cfg = MACHINE_RESET;
  logic [63:0] last_entry = '0;
  int          n_hdr = 0;
  int          n_seg = 0;
  int          n_end = 0;
  int          n_drop = 0;
  int          n_settings = 1;
  int          quiet_cycles = 0;

  elf_segment_security_checker DUT (.*);
  esc_report_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    report_ready = !(idle_enable && $urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (report_valid && report_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic esc_in_t noise_word();
    logic [383:0] bits;
    esc_in_t      w;
    for (int i = 0; i < 12; i++) begin
      bits[i*32 +: 32] = $urandom;
    end
    w = bits[IN_W-1:0];
    return w;
  endfunction

  function automatic esc_in_t bare_word(input op_t op);
    esc_in_t w;
    w = '0;
    w.op = op;
    return w;
  endfunction

  function automatic esc_in_t directed_header(input logic [31:0] magic, input logic [7:0] cls,
                                              input logic [15:0] ftype, input logic [15:0] mach,
                                              input logic [63:0] entry);
    esc_in_t w;
    w = bare_word(OP_HEADER);
    w.ident_magic = magic;
    w.ident_class = cls;
    w.file_type   = ftype;
    w.machine     = mach;
    w.entry_addr  = entry;
    return w;
  endfunction

  function automatic esc_in_t directed_segment(input logic [31:0] stype, input logic [2:0] flags,
                                               input logic [63:0] fsz, input logic [63:0] msz,
                                               input logic [63:0] va);
    esc_in_t w;
    w = bare_word(OP_SEGMENT);
    w.seg_type      = stype;
    w.seg_flags     = flags;
    w.seg_file_size = fsz;
    w.seg_mem_size  = msz;
    w.seg_vaddr     = va;
    return w;
  endfunction

  function automatic esc_in_t header_word(input int flaw);
    esc_in_t w;
    w = noise_word();
    w.op          = OP_HEADER;
    w.ident_magic = ELF_MAGIC_WORD;
    w.ident_class = CLASS_64;
    w.file_type   = $urandom_range(1) ? TYPE_EXEC : TYPE_DYN;
    w.machine     = mach_cfg;
    if ($urandom_range(1)) begin
      w.entry_addr = 64'h40_0000 + $urandom_range(0, 'hFFFF);
    end
    case (flaw)
      1: w.ident_magic = w.ident_magic ^ (32'd1 << $urandom_range(31));
      2: w.ident_class = CLASS_64 ^ 8'($urandom_range(1, 255));
      3: w.file_type = 16'($urandom);
      4: w.machine = mach_cfg ^ (16'd1 << $urandom_range(15));
      default: ;
    endcase
    return w;
  endfunction

  function automatic esc_in_t segment_word(input logic [63:0] entry);
    esc_in_t     w;
    logic [63:0] delta;
    w = noise_word();
    w.op = OP_SEGMENT;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: w.seg_type = SEG_LOAD;
      5, 6: w.seg_type = SEG_STACK;
      default: ;
    endcase
    case ($urandom_range(4))
      0: w.seg_file_size = '0;
      1, 2: w.seg_file_size = 64'($urandom_range(0, 'h3000));
      3: w.seg_file_size = ~64'($urandom_range(0, 'h3000));
      default: ;
    endcase
    case ($urandom_range(7))
      0: delta = '0;
      1: delta = {32'd0, pad_cfg};
      2: delta = {32'd0, pad_cfg} + 64'd1;
      3: delta = {32'd0, pad_cfg} - 64'd1;
      4: delta = w.seg_file_size;
      5: delta = 64'($urandom_range(0, 'h2000));
      6: delta = -64'($urandom_range(1, 'h100));
      default: delta = {$urandom, $urandom};
    endcase
    w.seg_mem_size = w.seg_file_size + delta;
    if ($urandom_range(2) != 0) begin
      w.seg_vaddr = entry - 64'($urandom_range(0, 'h4000));
    end
    return w;
  endfunction

  task automatic send_word(input esc_in_t w);
    @(negedge clk);
    while (idle_enable && $urandom_range(99) < 18) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item       = w;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    case (op_t'(w.op))
      OP_HEADER: begin
        n_hdr++;
        last_entry = w.entry_addr;
      end
      OP_SEGMENT: n_seg++;
      OP_END:     n_end++;
      default:    n_drop++;
    endcase
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == REG_PAD_LIMIT) begin
      pad_cfg = value;
    end else begin
      mach_cfg = value[15:0];
    end
  endtask

  task automatic send_table();
    esc_in_t w;
    int      segs;
    w = header_word(($urandom_range(4) == 0) ? $urandom_range(1, 4) : 0);
    if ($urandom_range(9) != 0) begin
      send_word(w);
    end
    segs = $urandom_range(0, 7);
    repeat (segs) begin
      if ($urandom_range(19) == 0) begin
        send_word(noise_word());
      end
      send_word(segment_word(last_entry));
    end
    if ($urandom_range(14) != 0) begin
      w = noise_word();
      w.op = OP_END;
      send_word(w);
    end
  endtask

  task automatic run_phase(input logic [31:0] pad, input logic [15:0] mach, input bit calm);
    int start;
    settle();
    write_reg(REG_PAD_LIMIT, pad);
    write_reg(REG_MACHINE, {16'd0, mach});
    n_settings++;
    idle_enable = !calm;
    start = n_hdr + n_seg + n_end;
    while (n_hdr + n_seg + n_end - start < PHASE_WORDS) begin
      send_table();
      if ($urandom_range(11) == 0) begin
        settle();
      end
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    esc_in_t w;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(bare_word(OP_END));
    send_word(directed_header(ELF_MAGIC_WORD, CLASS_64, TYPE_EXEC, MACHINE_RESET, 64'h40_1000));
    send_word(directed_segment(SEG_LOAD, 3'b101, 64'h2000, 64'h2000, 64'h40_0000));
    send_word(directed_segment(SEG_LOAD, 3'b110, '0, '1, 64'h60_0000));
    send_word(directed_segment(SEG_LOAD, 3'b011, 64'h8000_0000_0000_0000, '1, '0));
    send_word(directed_segment(SEG_STACK, 3'b111, '1, '0, '1));
    send_word(directed_segment(SEG_STACK, 3'b110, '0, '0, '0));
    send_word(directed_segment(SEG_STACK, 3'b001, '0, '0, '0));
    send_word(directed_segment(32'hFFFF_FFFF, 3'b111, '0, '1, '0));
    w = noise_word();
    w.op = OP_NONE;
    send_word(w);
    send_word(bare_word(OP_END));
    send_word(directed_header(32'h464C_4580, CLASS_64, TYPE_EXEC, MACHINE_RESET, '0));
    send_word(directed_header(ELF_MAGIC_WORD, 8'd1, TYPE_EXEC, MACHINE_RESET, '0));
    send_word(directed_header(ELF_MAGIC_WORD, CLASS_64, 16'd1, MACHINE_RESET, '0));
    send_word(directed_header(ELF_MAGIC_WORD, CLASS_64, TYPE_DYN, 16'hFFFF, '0));
    send_word(directed_header('0, '0, '0, '0, '1));
    send_word(directed_segment(SEG_LOAD, 3'b010, 64'h10, 64'h2000, 64'hFFFF_FFFF_FFFF_F000));
    send_word(bare_word(OP_END));
    send_word(directed_header(ELF_MAGIC_WORD, CLASS_64, TYPE_DYN, MACHINE_RESET, '1));
    send_word(directed_segment(SEG_LOAD, 3'b010, '0, 64'd1, '1));
    send_word(bare_word(OP_END));
    send_word(directed_header(ELF_MAGIC_WORD, CLASS_64, TYPE_EXEC, MACHINE_RESET, 64'h1000));
    send_word(directed_segment(SEG_LOAD, 3'b100, 64'h2_0000, 64'h2_0000 + 64'd102400,
                               64'h1001));
    send_word(directed_segment(SEG_LOAD, 3'b101, '0, '0, 64'h1000));
    send_word(bare_word(OP_END));

    run_phase(32'd0, 16'd0, 1'b0);
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    run_phase(PAD_LIMIT_RESET, MACHINE_RESET, 1'b0);
    run_phase($urandom, 16'($urandom), 1'b0);
    run_phase(32'($urandom_range(0, 'h20000)), MACHINE_RESET, 1'b0);
    settle();

    $display("Run covered %0d file headers, %0d program headers, %0d end words and %0d dropped",
             n_hdr, n_seg, n_end, n_drop);
    $display("words under %0d register settings, with %0d report words checked.",
             n_settings, reports_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### elf_segment_security_checker.f
rtl/esc_pkg.sv
rtl/esc_front.sv
rtl/esc_queue.sv
rtl/esc_back.sv
rtl/elf_segment_security_checker.sv
rtl/esc_checker.sv
tb/esc_report_checker.sv
tb/tb_elf_segment_security_checker.sv
